@@ rtl/core/trr_pkg.sv @@
package trr_pkg;

  // Row geometry
  localparam int unsigned ROW_COLUMNS = 40;
  localparam int unsigned TEXT_ROWS   = 24;
  localparam int unsigned MAX_WRITES  = 4;

  localparam logic [5:0] COL_LIMIT   = 6'(ROW_COLUMNS);
  localparam logic [5:0] EDGE_COL    = 6'(ROW_COLUMNS - 2);
  localparam logic [5:0] HEADER_COLS = 6'd8;
  localparam logic [4:0] BOTTOM_ROW  = 5'(TEXT_ROWS - 1);

  // Item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRIMARY   = 2'd0;
  localparam logic [1:0] CFG_SECONDARY = 2'd1;
  localparam logic [1:0] CFG_LANGUAGE  = 2'd2;
  localparam logic [1:0] CFG_FLAGS     = 2'd3;

  // Spacing attribute codes
  localparam logic [7:0] CODE_FLASH_ON    = 8'h08;
  localparam logic [7:0] CODE_FLASH_OFF   = 8'h09;
  localparam logic [7:0] CODE_BOX_START   = 8'h0A;
  localparam logic [7:0] CODE_BOX_END     = 8'h0B;
  localparam logic [7:0] CODE_NORMAL_SIZE = 8'h0C;
  localparam logic [7:0] CODE_DBL_HEIGHT  = 8'h0D;
  localparam logic [7:0] CODE_DBL_WIDTH   = 8'h0E;
  localparam logic [7:0] CODE_DBL_SIZE    = 8'h0F;
  localparam logic [7:0] CODE_CONCEAL     = 8'h18;
  localparam logic [7:0] CODE_CONTIGUOUS  = 8'h19;
  localparam logic [7:0] CODE_SEPARATED   = 8'h1A;
  localparam logic [7:0] CODE_ESC         = 8'h1B;
  localparam logic [7:0] CODE_BLACK_BG    = 8'h1C;
  localparam logic [7:0] CODE_NEW_BG      = 8'h1D;
  localparam logic [7:0] CODE_HOLD        = 8'h1E;
  localparam logic [7:0] CODE_RELEASE     = 8'h1F;
  localparam logic [7:0] GLYPH_SPACE      = 8'h20;

  // Low seven bits of the double-height and double-size codes
  localparam logic [6:0] LOW_DBL_HEIGHT = 7'h0D;
  localparam logic [6:0] LOW_DBL_SIZE   = 7'h0F;

  // Charset codes
  localparam logic [4:0] CS_MOSAIC     = 5'd25;
  localparam logic [4:0] CS_MOSAIC_SEP = 5'd26;

  localparam logic [2:0] COLOUR_BLACK = 3'd0;
  localparam logic [2:0] COLOUR_WHITE = 3'd7;

  // Cell halves
  localparam logic [1:0] PART_NONE   = 2'd0;
  localparam logic [1:0] PART_FIRST  = 2'd1;
  localparam logic [1:0] PART_SECOND = 2'd2;

  typedef enum logic [1:0] {
    SZ_NORMAL  = 2'd0,
    SZ_DWIDTH  = 2'd1,
    SZ_DHEIGHT = 2'd2,
    SZ_DSIZE   = 2'd3
  } size_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] code_byte;
    logic [4:0] row;
    logic [5:0] column;
  } in_t;

  typedef struct packed {
    logic [5:0] cell_column;
    logic [4:0] cell_row;
    logic [7:0] glyph_code;
    logic [4:0] charset_code;
    logic [2:0] fore_colour;
    logic [2:0] back_colour;
    logic [2:0] attr_flags;
    logic [1:0] width_part;
    logic [1:0] height_part;
    logic       line_double;
    logic       last_write;
  } out_t;

  typedef struct packed {
    logic [3:0] primary_block;
    logic [3:0] secondary_block;
    logic [2:0] page_language;
    logic [7:0] page_flags;
  } cfg_t;

  typedef struct packed {
    logic [2:0] fg;
    logic [2:0] bg;
    logic [4:0] charset;
    logic       flash;
    logic       conceal;
    logic       boxed;
  } attr_t;

  typedef struct packed {
    logic       row_double_seen;
    size_t      size_mode;
    logic       hold_active;
    logic [7:0] held_glyph;
    logic [4:0] held_charset;
    logic       second_set_on;
    logic       mosaic_on;
    logic       separated_on;
    logic       skip_one;
    attr_t      attrs;
  } state_t;

  // G0 charset per font block and national option
  localparam logic [4:0] G0_TABLE [16][8] = '{
    '{5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7 },
    '{5'd9,  5'd1,  5'd2,  5'd3,  5'd4,  5'd7,  5'd6,  5'd7 },
    '{5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd10, 5'd7 },
    '{5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd11, 5'd7,  5'd12},
    '{5'd13, 5'd1,  5'd14, 5'd15, 5'd16, 5'd17, 5'd6,  5'd18},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd10, 5'd20},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18},
    '{5'd0,  5'd18, 5'd18, 5'd18, 5'd4,  5'd18, 5'd18, 5'd22},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd24, 5'd18, 5'd22},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18}
  };

  function automatic logic [4:0] g0_lookup(input logic [3:0] blk, input logic [2:0] low);
    return G0_TABLE[blk][low];
  endfunction

  // Charset in force with all registers at reset
  localparam logic [4:0] CS_RESET = 5'd0;

  localparam attr_t ATTR_RESET = '{
    fg: COLOUR_WHITE, bg: COLOUR_BLACK, charset: CS_RESET,
    flash: 1'b0, conceal: 1'b0, boxed: 1'b0
  };

  localparam state_t STATE_RESET = '{
    row_double_seen: 1'b0, size_mode: SZ_NORMAL, hold_active: 1'b0,
    held_glyph: GLYPH_SPACE, held_charset: CS_RESET, second_set_on: 1'b0,
    mosaic_on: 1'b0, separated_on: 1'b0, skip_one: 1'b0, attrs: ATTR_RESET
  };

endpackage

@@ rtl/core/trr_step.sv @@
module trr_step
  import trr_pkg::*;
(
  input  state_t           st,
  input  in_t              item,
  input  logic [7:0]       ttc,
  input  cfg_t             cfg,
  output state_t           st_nxt,
  output out_t [3:0]       res,
  output logic [2:0]       n_res
);

  function automatic out_t mk_cell(input logic [5:0] col, input logic [4:0] row,
                                   input attr_t a, input logic [7:0] glyph,
                                   input logic [4:0] cs, input logic [1:0] wp,
                                   input logic [1:0] hp, input logic ld);
    out_t c;
    c.cell_column  = col;
    c.cell_row     = row;
    c.glyph_code   = glyph;
    c.charset_code = cs;
    c.fore_colour  = a.fg;
    c.back_colour  = a.bg;
    c.attr_flags   = {a.boxed, a.conceal, a.flash};
    c.width_part   = wp;
    c.height_part  = hp;
    c.line_double  = ld;
    c.last_write   = 1'b0;
    return c;
  endfunction

  state_t     s;
  attr_t      c2;
  logic [4:0] fg0;
  logic [4:0] sg0;
  logic [7:0] glyph;
  logic [4:0] cs;
  logic [5:0] col;
  logic [5:0] col_r1;
  logic [4:0] row;
  logic [4:0] fill_row;
  logic       blank_next;

  // National option bits are reversed into the low code page bits
  assign fg0 = g0_lookup(cfg.primary_block,
                         {cfg.page_language[0], cfg.page_language[1], cfg.page_language[2]});
  assign sg0 = g0_lookup(cfg.secondary_block, 3'd0);

  assign col      = item.column;
  assign row      = item.row;
  assign col_r1   = col + 6'd1;
  assign fill_row = row + 5'd1;

  always_comb begin
    s          = st;
    c2         = st.attrs;
    glyph      = GLYPH_SPACE;
    cs         = st.attrs.charset;
    blank_next = 1'b0;
    n_res      = 3'd0;
    res        = '0;

    if (col < COL_LIMIT) begin
      if (item.mode == MODE_LOAD) begin
        // Note double-height or double-size codes outside the header
        if (col == 6'd0) s.row_double_seen = 1'b0;
        if (!(row == 5'd0 && col < HEADER_COLS) &&
            (item.code_byte[6:0] == LOW_DBL_HEIGHT || item.code_byte[6:0] == LOW_DBL_SIZE))
          s.row_double_seen = 1'b1;
      end else begin
        // Row start
        if (col == 6'd0) begin
          s.hold_active   = 1'b0;
          s.held_glyph    = GLYPH_SPACE;
          s.held_charset  = fg0;
          s.size_mode     = SZ_NORMAL;
          s.second_set_on = 1'b0;
          s.mosaic_on     = 1'b0;
          s.separated_on  = 1'b0;
          s.skip_one      = 1'b0;
          s.attrs         = ATTR_RESET;
          s.attrs.charset = fg0;
          s.attrs.boxed   = (row == 5'd0 && cfg.page_flags[4]) || (|cfg.page_flags[6:5]);
        end

        if (!(row == 5'd0 && col < HEADER_COLS)) begin
          // Set-at codes
          unique case (ttc)
            CODE_FLASH_OFF: s.attrs.flash = 1'b0;
            CODE_NORMAL_SIZE: begin
              if (s.size_mode != SZ_NORMAL) begin
                s.size_mode    = SZ_NORMAL;
                s.held_glyph   = GLYPH_SPACE;
                s.held_charset = fg0;
              end
            end
            CODE_CONCEAL: s.attrs.conceal = 1'b1;
            CODE_CONTIGUOUS: begin
              s.separated_on = 1'b0;
              if (s.mosaic_on) s.attrs.charset = CS_MOSAIC;
            end
            CODE_SEPARATED: begin
              s.separated_on = 1'b1;
              if (s.mosaic_on) s.attrs.charset = CS_MOSAIC_SEP;
            end
            CODE_BLACK_BG: s.attrs.bg = COLOUR_BLACK;
            CODE_NEW_BG:   s.attrs.bg = s.attrs.fg;
            CODE_HOLD:     s.hold_active = 1'b1;
            default: ;
          endcase

          // Character choice: space, held mosaic or the code itself
          c2 = s.attrs;
          if (ttc < GLYPH_SPACE) begin
            if (s.hold_active) begin
              glyph      = s.held_glyph;
              c2.charset = s.held_charset;
            end
          end else begin
            glyph = ttc;
            if (s.mosaic_on) begin
              if (ttc[5]) begin
                s.held_glyph   = ttc;
                s.held_charset = s.attrs.charset;
              end else begin
                c2.charset = s.second_set_on ? sg0 : fg0;
              end
            end
          end
          cs = c2.charset;

          // Size fallback at the bottom and right edges
          if (row >= BOTTOM_ROW) begin
            if (s.size_mode == SZ_DHEIGHT) s.size_mode = SZ_NORMAL;
            if (s.size_mode == SZ_DSIZE)   s.size_mode = SZ_DWIDTH;
          end
          if (col >= EDGE_COL) begin
            if (s.size_mode == SZ_DWIDTH) s.size_mode = SZ_NORMAL;
            if (s.size_mode == SZ_DSIZE)  s.size_mode = SZ_DHEIGHT;
          end

          // Cell writes
          blank_next = s.row_double_seen && (row < BOTTOM_ROW);
          if (s.skip_one) begin
            s.skip_one = 1'b0;
          end else begin
            unique case (s.size_mode)
              SZ_NORMAL: begin
                res[0] = mk_cell(col, row, c2, glyph, cs, PART_NONE, PART_NONE,
                                 s.row_double_seen);
                res[1] = mk_cell(col, fill_row, c2, GLYPH_SPACE, fg0, PART_NONE, PART_NONE,
                                 s.row_double_seen);
                n_res  = blank_next ? 3'd2 : 3'd1;
              end
              SZ_DWIDTH: begin
                res[0] = mk_cell(col, row, c2, glyph, cs, PART_FIRST, PART_NONE,
                                 s.row_double_seen);
                res[1] = mk_cell(col_r1, row, c2, glyph, cs, PART_SECOND, PART_NONE,
                                 s.row_double_seen);
                res[2] = mk_cell(col, fill_row, c2, GLYPH_SPACE, fg0, PART_NONE, PART_NONE,
                                 s.row_double_seen);
                res[3] = mk_cell(col_r1, fill_row, c2, GLYPH_SPACE, fg0, PART_NONE,
                                 PART_NONE, s.row_double_seen);
                n_res  = blank_next ? 3'd4 : 3'd2;
                s.skip_one = 1'b1;
              end
              SZ_DHEIGHT: begin
                res[0] = mk_cell(col, row, c2, glyph, cs, PART_NONE, PART_FIRST,
                                 s.row_double_seen);
                res[1] = mk_cell(col, fill_row, c2, glyph, cs, PART_NONE, PART_SECOND,
                                 s.row_double_seen);
                n_res  = 3'd2;
              end
              SZ_DSIZE: begin
                res[0] = mk_cell(col, row, c2, glyph, cs, PART_FIRST, PART_FIRST,
                                 s.row_double_seen);
                res[1] = mk_cell(col_r1, row, c2, glyph, cs, PART_SECOND, PART_FIRST,
                                 s.row_double_seen);
                res[2] = mk_cell(col, fill_row, c2, glyph, cs, PART_FIRST, PART_SECOND,
                                 s.row_double_seen);
                res[3] = mk_cell(col_r1, fill_row, c2, glyph, cs, PART_SECOND, PART_SECOND,
                                 s.row_double_seen);
                n_res  = 3'd4;
                s.skip_one = 1'b1;
              end
              default: ;
            endcase
          end

          // Mark the final write of the item
          unique case (n_res)
            3'd1:    res[0].last_write = 1'b1;
            3'd2:    res[1].last_write = 1'b1;
            3'd4:    res[3].last_write = 1'b1;
            default: ;
          endcase

          // Set-after codes
          if (ttc[7:3] == 5'b00000) begin
            if (s.mosaic_on) begin
              s.held_glyph   = GLYPH_SPACE;
              s.held_charset = fg0;
            end
            s.attrs.fg      = ttc[2:0];
            s.mosaic_on     = 1'b0;
            s.attrs.charset = s.second_set_on ? sg0 : fg0;
            s.attrs.conceal = 1'b0;
          end else if (ttc[7:3] == 5'b00010) begin
            if (!s.mosaic_on) begin
              s.held_glyph   = GLYPH_SPACE;
              s.held_charset = fg0;
            end
            s.attrs.fg      = ttc[2:0];
            s.attrs.charset = s.separated_on ? CS_MOSAIC_SEP : CS_MOSAIC;
            s.mosaic_on     = 1'b1;
            s.attrs.conceal = 1'b0;
          end else begin
            unique case (ttc)
              CODE_FLASH_ON:  s.attrs.flash = 1'b1;
              CODE_BOX_START: s.attrs.boxed = 1'b1;
              CODE_BOX_END:   s.attrs.boxed = 1'b0;
              CODE_DBL_HEIGHT: begin
                if (s.size_mode != SZ_DHEIGHT) begin
                  s.size_mode    = SZ_DHEIGHT;
                  s.held_glyph   = GLYPH_SPACE;
                  s.held_charset = fg0;
                end
              end
              CODE_DBL_WIDTH: begin
                if (s.size_mode != SZ_DWIDTH) begin
                  s.size_mode    = SZ_DWIDTH;
                  s.held_glyph   = GLYPH_SPACE;
                  s.held_charset = fg0;
                end
              end
              CODE_DBL_SIZE: begin
                if (s.size_mode != SZ_DSIZE) begin
                  s.size_mode    = SZ_DSIZE;
                  s.held_glyph   = GLYPH_SPACE;
                  s.held_charset = fg0;
                end
              end
              CODE_ESC: begin
                s.second_set_on = !s.second_set_on;
                if (!s.mosaic_on) s.attrs.charset = s.second_set_on ? sg0 : fg0;
              end
              CODE_RELEASE: s.hold_active = 1'b0;
              default: ;
            endcase
          end
        end
      end
    end

    st_nxt = s;
  end

endmodule

@@ rtl/core/teletext_row_attribute_renderer_unit.sv @@
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_data  (in_t: mode, code_byte, row, column)
// out_      output     out_valid / out_stall  out_data (out_t: one cell write)
// cfg_      input      cfg_we                 cfg_index, cfg_data
//
// A transaction is taken into an input register, where the line store is written (load) or
// read (render). A combinational decode of it fills a four-entry result buffer.
// Cell writes are offered from that buffer, which is registered after the input register;
// a render offers its cell writes (up to four) one per cycle while out_stall is low, and
// loads and silent renders pass at one per cycle while the input does not stall.
// The input stalls only while a decoded render waits for the result buffer to drain.
// Synchronous active-low reset clears control and row state; the line store is not cleared.
module teletext_row_attribute_renderer_unit
  import trr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t       cfg_r;
  logic [7:0] line_mem [ROW_COLUMNS];

  logic       s1_valid_r;
  in_t        s1_item_r;
  logic [7:0] s1_ttc_r;

  state_t     state_r;
  state_t     state_nxt;
  out_t [MAX_WRITES-1:0] dec_res;
  logic [2:0] dec_n;

  out_t [MAX_WRITES-1:0] buf_r;
  logic       buf_valid_r;
  logic [2:0] buf_cnt_r;
  logic [1:0] buf_ptr_r;

  logic       in_take;
  logic       out_take;
  logic       buf_last;
  logic       buf_free;
  logic       s1_go;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRIMARY:   cfg_r.primary_block   <= cfg_data[3:0];
        CFG_SECONDARY: cfg_r.secondary_block <= cfg_data[3:0];
        CFG_LANGUAGE:  cfg_r.page_language   <= cfg_data[2:0];
        CFG_FLAGS:     cfg_r.page_flags      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake
  assign out_take = buf_valid_r && !out_stall;
  assign buf_last = ({1'b0, buf_ptr_r} == (buf_cnt_r - 3'd1));
  assign buf_free = !buf_valid_r || (out_take && buf_last);
  assign s1_go    = s1_valid_r && ((dec_n == 3'd0) || buf_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  // Line store: written by loads, read into the input stage by renders
  always_ff @(posedge clk) begin
    if (in_take && in_data.column < COL_LIMIT) begin
      if (in_data.mode == MODE_LOAD) line_mem[in_data.column] <= in_data.code_byte;
      else                           s1_ttc_r <= line_mem[in_data.column];
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item_r <= in_data;
  end

  // Column decode
  trr_step u_step (
    .st     (state_r),
    .item   (s1_item_r),
    .ttc    (s1_ttc_r),
    .cfg    (cfg_r),
    .st_nxt (state_nxt),
    .res    (dec_res),
    .n_res  (dec_n)
  );

  // Row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  // Result buffer, drained one cell write per cycle while out_stall is low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      buf_cnt_r   <= 3'd0;
      buf_ptr_r   <= 2'd0;
    end else if (s1_go && dec_n != 3'd0) begin
      buf_valid_r <= 1'b1;
      buf_cnt_r   <= dec_n;
      buf_ptr_r   <= 2'd0;
    end else if (out_take) begin
      if (buf_last) buf_valid_r <= 1'b0;
      else          buf_ptr_r   <= buf_ptr_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && dec_n != 3'd0) buf_r <= dec_res;
  end

  assign out_valid = buf_valid_r;
  assign out_data  = buf_r[buf_ptr_r];

endmodule

@@ tb/tb.sv @@
module tb;
  import trr_pkg::*;

  localparam int          HALF_PERIOD   = 6;
  localparam int          RESET_CYCLES  = 7;
  localparam int          RANDOM_ITEMS  = 400;
  localparam int          MAX_GAP       = 18;
  localparam int          LONG_HOLD     = 250;
  localparam int          IDLE_PAD      = 10;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int          REPORT_LIMIT  = 10;

  // Colour code ranges of the alphanumeric and mosaic set-after codes
  localparam logic [7:0] ALPHA_LAST   = 8'h07;
  localparam logic [7:0] MOSAIC_FIRST = 8'h10;
  localparam logic [7:0] MOSAIC_LAST  = 8'h17;

  // Golden row decoder plus the queue of cell writes still owed by the block
  class cell_scoreboard;
    cfg_t       regs;
    logic [7:0] row_bytes [ROW_COLUMNS];
    logic       dbl_row, hold_on, alt_set, gfx, sep_gfx, skip_next;
    size_t      sz;
    logic [7:0] hold_glyph;
    logic [4:0] hold_cs;
    attr_t      attrs;
    out_t       expected_cells[$];
    int         mismatches;

    function new();
      regs = '0;
      foreach (row_bytes[i]) row_bytes[i] = 8'h00;
      dbl_row    = 1'b0;
      hold_on    = 1'b0;
      alt_set    = 1'b0;
      gfx        = 1'b0;
      sep_gfx    = 1'b0;
      skip_next  = 1'b0;
      sz         = SZ_NORMAL;
      mismatches = 0;
      attrs      = plain_attrs();
      drop_hold();
    endfunction

    // G0 charset for a font block and a national option
    function logic [4:0] font_charset(logic [3:0] blk, logic [2:0] low);
      logic [4:0] map [8];
      case (blk)
        4'd0:    map = '{0, 1, 2, 3, 4, 5, 6, 7};
        4'd1:    map = '{9, 1, 2, 3, 4, 7, 6, 7};
        4'd2:    map = '{0, 1, 2, 3, 4, 5, 10, 7};
        4'd3:    map = '{7, 7, 7, 7, 7, 11, 7, 12};
        4'd4:    map = '{13, 1, 14, 15, 16, 17, 6, 18};
        4'd6:    map = '{18, 18, 18, 18, 18, 18, 10, 20};
        4'd8:    map = '{0, 18, 18, 18, 4, 18, 18, 22};
        4'd10:   map = '{18, 18, 18, 18, 18, 24, 18, 22};
        default: map = '{18, 18, 18, 18, 18, 18, 18, 18};
      endcase
      return map[low];
    endfunction

    // National option bits arrive reversed
    function logic [4:0] primary_cs();
      logic [2:0] lang;
      lang = regs.page_language;
      return font_charset(regs.primary_block, {lang[0], lang[1], lang[2]});
    endfunction

    function logic [4:0] text_cs();
      return alt_set ? font_charset(regs.secondary_block, 3'd0) : primary_cs();
    endfunction

    function void drop_hold();
      hold_glyph = GLYPH_SPACE;
      hold_cs    = primary_cs();
    endfunction

    function attr_t plain_attrs();
      attr_t a;
      a.fg      = COLOUR_WHITE;
      a.bg      = COLOUR_BLACK;
      a.charset = primary_cs();
      a.flash   = 1'b0;
      a.conceal = 1'b0;
      a.boxed   = 1'b0;
      return a;
    endfunction

    function out_t make_cell(logic [5:0] c, logic [4:0] r, attr_t a, logic [7:0] glyph,
                             logic [4:0] cs, logic [1:0] wpart, logic [1:0] hpart);
      out_t o;
      o.cell_column  = c;
      o.cell_row     = r;
      o.glyph_code   = glyph;
      o.charset_code = cs;
      o.fore_colour  = a.fg;
      o.back_colour  = a.bg;
      o.attr_flags   = {a.boxed, a.conceal, a.flash};
      o.width_part   = wpart;
      o.height_part  = hpart;
      o.line_double  = dbl_row;
      o.last_write   = 1'b0;
      return o;
    endfunction

    // Decode one column of the stored row into its cell writes
    function void render_column(logic [4:0] r, logic [5:0] c);
      attr_t      shown;
      logic [7:0] code, glyph;
      logic [4:0] cs, below;
      logic       blank;
      out_t       cells[$];
      out_t       tail;

      // column 0 restarts every row attribute but the double-row flag
      if (c == 6'd0) begin
        hold_on   = 1'b0;
        drop_hold();
        sz        = SZ_NORMAL;
        alt_set   = 1'b0;
        gfx       = 1'b0;
        sep_gfx   = 1'b0;
        skip_next = 1'b0;
        attrs     = plain_attrs();
        if ((r == 5'd0 && regs.page_flags[4]) || regs.page_flags[6:5] != 2'b00) begin
          attrs.boxed = 1'b1;
        end
      end
      if (r == 5'd0 && c < HEADER_COLS) return;

      code = row_bytes[c];

      // set-at codes
      case (code)
        CODE_FLASH_OFF:   attrs.flash = 1'b0;
        CODE_NORMAL_SIZE: begin
          if (sz != SZ_NORMAL) begin
            sz = SZ_NORMAL;
            drop_hold();
          end
        end
        CODE_CONCEAL:     attrs.conceal = 1'b1;
        CODE_CONTIGUOUS: begin
          sep_gfx = 1'b0;
          if (gfx) attrs.charset = CS_MOSAIC;
        end
        CODE_SEPARATED: begin
          sep_gfx = 1'b1;
          if (gfx) attrs.charset = CS_MOSAIC_SEP;
        end
        CODE_BLACK_BG:    attrs.bg = COLOUR_BLACK;
        CODE_NEW_BG:      attrs.bg = attrs.fg;
        CODE_HOLD:        hold_on = 1'b1;
        default: ;
      endcase

      // character choice: space, held mosaic or the byte itself
      shown = attrs;
      if (code < GLYPH_SPACE) begin
        if (hold_on) begin
          glyph         = hold_glyph;
          shown.charset = hold_cs;
        end else begin
          glyph = GLYPH_SPACE;
        end
      end else begin
        glyph = code;
        if (gfx) begin
          if (code[5]) begin
            hold_glyph = code;
            hold_cs    = attrs.charset;
          end else begin
            shown.charset = text_cs();
          end
        end
      end
      cs = shown.charset;

      // fall back at the bottom and right edges
      if (r >= BOTTOM_ROW) begin
        if (sz == SZ_DHEIGHT) sz = SZ_NORMAL;
        if (sz == SZ_DSIZE) sz = SZ_DWIDTH;
      end
      if (c >= EDGE_COL) begin
        if (sz == SZ_DWIDTH) sz = SZ_NORMAL;
        if (sz == SZ_DSIZE) sz = SZ_DHEIGHT;
      end

      below = r + 5'd1;
      blank = dbl_row && (r < BOTTOM_ROW);
      if (skip_next) begin
        skip_next = 1'b0;
      end else begin
        case (sz)
          SZ_NORMAL: begin
            cells.push_back(make_cell(c, r, shown, glyph, cs, PART_NONE, PART_NONE));
            if (blank) begin
              cells.push_back(make_cell(c, below, shown, GLYPH_SPACE, primary_cs(),
                                        PART_NONE, PART_NONE));
            end
          end
          SZ_DWIDTH: begin
            cells.push_back(make_cell(c, r, shown, glyph, cs, PART_FIRST, PART_NONE));
            cells.push_back(make_cell(c + 6'd1, r, shown, glyph, cs, PART_SECOND, PART_NONE));
            if (blank) begin
              cells.push_back(make_cell(c, below, shown, GLYPH_SPACE, primary_cs(),
                                        PART_NONE, PART_NONE));
              cells.push_back(make_cell(c + 6'd1, below, shown, GLYPH_SPACE, primary_cs(),
                                        PART_NONE, PART_NONE));
            end
            skip_next = 1'b1;
          end
          SZ_DHEIGHT: begin
            cells.push_back(make_cell(c, r, shown, glyph, cs, PART_NONE, PART_FIRST));
            cells.push_back(make_cell(c, below, shown, glyph, cs, PART_NONE, PART_SECOND));
          end
          default: begin
            cells.push_back(make_cell(c, r, shown, glyph, cs, PART_FIRST, PART_FIRST));
            cells.push_back(make_cell(c + 6'd1, r, shown, glyph, cs, PART_SECOND, PART_FIRST));
            cells.push_back(make_cell(c, below, shown, glyph, cs, PART_FIRST, PART_SECOND));
            cells.push_back(make_cell(c + 6'd1, below, shown, glyph, cs,
                                      PART_SECOND, PART_SECOND));
            skip_next = 1'b1;
          end
        endcase
      end
      if (cells.size() > 0) begin
        tail = cells.pop_back();
        tail.last_write = 1'b1;
        cells.push_back(tail);
        foreach (cells[i]) expected_cells.push_back(cells[i]);
      end

      // set-after codes
      if (code <= ALPHA_LAST) begin
        if (gfx) drop_hold();
        attrs.fg      = code[2:0];
        gfx           = 1'b0;
        attrs.charset = text_cs();
        attrs.conceal = 1'b0;
      end else if (code >= MOSAIC_FIRST && code <= MOSAIC_LAST) begin
        if (!gfx) drop_hold();
        attrs.fg      = code[2:0];
        attrs.charset = sep_gfx ? CS_MOSAIC_SEP : CS_MOSAIC;
        gfx           = 1'b1;
        attrs.conceal = 1'b0;
      end else begin
        case (code)
          CODE_FLASH_ON:  attrs.flash = 1'b1;
          CODE_BOX_START: attrs.boxed = 1'b1;
          CODE_BOX_END:   attrs.boxed = 1'b0;
          CODE_DBL_HEIGHT: begin
            if (sz != SZ_DHEIGHT) begin
              sz = SZ_DHEIGHT;
              drop_hold();
            end
          end
          CODE_DBL_WIDTH: begin
            if (sz != SZ_DWIDTH) begin
              sz = SZ_DWIDTH;
              drop_hold();
            end
          end
          CODE_DBL_SIZE: begin
            if (sz != SZ_DSIZE) begin
              sz = SZ_DSIZE;
              drop_hold();
            end
          end
          CODE_ESC: begin
            alt_set = !alt_set;
            if (!gfx) attrs.charset = text_cs();
          end
          CODE_RELEASE:   hold_on = 1'b0;
          default: ;
        endcase
      end
    endfunction

    // Accepted input transaction: update the store or decode a column
    function void note_input(in_t t);
      if (t.column >= COL_LIMIT) return;
      if (t.mode == MODE_LOAD) begin
        row_bytes[t.column] = t.code_byte;
        if (t.column == 6'd0) dbl_row = 1'b0;
        if (!(t.row == 5'd0 && t.column < HEADER_COLS) &&
            (t.code_byte[6:0] == LOW_DBL_HEIGHT || t.code_byte[6:0] == LOW_DBL_SIZE)) begin
          dbl_row = 1'b1;
        end
      end else begin
        render_column(t.row, t.column);
      end
    endfunction

    function string describe(out_t o);
      string head;
      head = $sformatf("col=%0d row=%0d glyph=%h cs=%0d fg=%0d bg=%0d",
                       o.cell_column, o.cell_row, o.glyph_code, o.charset_code,
                       o.fore_colour, o.back_colour);
      return {head, $sformatf(" flags=%b w=%0d h=%0d dbl=%b last=%b",
                              o.attr_flags, o.width_part, o.height_part,
                              o.line_double, o.last_write)};
    endfunction

    // Accepted result transaction against the oldest owed cell write
    function void check_cell(out_t got);
      out_t want;
      if (expected_cells.size() == 0) begin
        if (mismatches < REPORT_LIMIT) $display("unexpected cell write: %s", describe(got));
        mismatches++;
        return;
      end
      want = expected_cells.pop_front();
      if (got.cell_column !== want.cell_column || got.cell_row !== want.cell_row ||
          got.glyph_code !== want.glyph_code || got.charset_code !== want.charset_code ||
          got.fore_colour !== want.fore_colour || got.back_colour !== want.back_colour ||
          got.attr_flags !== want.attr_flags || got.width_part !== want.width_part ||
          got.height_part !== want.height_part || got.line_double !== want.line_double ||
          got.last_write !== want.last_write) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("cell write mismatch");
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  cell_scoreboard sb;
  bit          col_loaded [ROW_COLUMNS];
  bit          long_hold_req;
  bit          tx_calm;
  int          items_sent;
  int unsigned cycle_count;

  teletext_row_attribute_renderer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_cell(out_data);
  end

  function automatic int draw_gap(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, MAX_GAP);
  endfunction

  // Result side: random stalls per transaction, calm stretches and one long hold-off
  initial begin : result_sink
    int wait_cycles;
    int calm_left;
    out_stall = 1'b0;
    calm_left = 0;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end
      if (calm_left > 0) begin
        calm_left--;
        wait_cycles = 0;
      end else begin
        if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(10, 60);
        wait_cycles = draw_gap(1'b0);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one transaction; valid stays up afterwards so back-to-back items need no gap
  task automatic send_item(input in_t t);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(t);
    if (t.column < COL_LIMIT) begin
      items_sent++;
      if (t.mode == MODE_LOAD) col_loaded[t.column] = 1'b1;
    end
    @(negedge clk);
  endtask

  task automatic load_byte(input int r, input int c, input logic [7:0] b);
    in_t t;
    t.mode      = MODE_LOAD;
    t.code_byte = b;
    t.row       = r[4:0];
    t.column    = c[5:0];
    send_item(t);
  endtask

  task automatic render_at(input int r, input int c);
    in_t t;
    t.mode      = MODE_RENDER;
    t.code_byte = 8'($urandom);
    t.row       = r[4:0];
    t.column    = c[5:0];
    send_item(t);
  endtask

  // Occasional junk: out-of-range columns or a stray render out of order
  task automatic maybe_noise();
    in_t t;
    int  k;
    int  c;
    k = $urandom_range(0, 39);
    if (k < 2) begin
      t.mode      = 1'($urandom);
      t.code_byte = 8'($urandom);
      t.row       = 5'($urandom);
      t.column    = 6'($urandom_range(ROW_COLUMNS, 63));
      send_item(t);
    end else if (k == 2) begin
      c = $urandom_range(0, ROW_COLUMNS - 1);
      if (col_loaded[c]) render_at($urandom_range(0, 31), c);
    end
  endtask

  // Let every owed result arrive, then allow the pipeline to empty
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_cells.size() != 0) @(negedge clk);
    repeat (IDLE_PAD) @(negedge clk);
  endtask

  task automatic program_regs(input cfg_t v);
    logic [1:0] idx  [4];
    logic [7:0] vals [4];
    idx  = '{CFG_PRIMARY, CFG_SECONDARY, CFG_LANGUAGE, CFG_FLAGS};
    vals = '{{4'h0, v.primary_block}, {4'h0, v.secondary_block},
             {5'h00, v.page_language}, v.page_flags};
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_we  <= 1'b0;
    sb.regs = v;
  endtask

  // Page bytes weighted towards spacing attributes and size codes
  function automatic logic [7:0] pick_code();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 8'($urandom_range(0, 31));
    if (k < 50) begin
      case ($urandom_range(0, 3))
        0:       return CODE_NORMAL_SIZE;
        1:       return CODE_DBL_HEIGHT;
        2:       return CODE_DBL_WIDTH;
        default: return CODE_DBL_SIZE;
      endcase
    end
    if (k < 85) return 8'($urandom_range(32, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic int pick_row();
    int k;
    k = $urandom_range(0, 19);
    if (k < 12) return $urandom_range(1, TEXT_ROWS - 2);
    if (k < 15) return TEXT_ROWS - 1;
    if (k < 17) return 0;
    return $urandom_range(TEXT_ROWS, 31);
  endfunction

  // Main stimulus
  initial begin : stimulus
    int   seq;
    int   base;
    int   loads;
    int   renders;
    int   r;
    cfg_t setting;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_PRIMARY;
    cfg_data      = 8'h00;
    long_hold_req = 1'b0;
    tx_calm       = 1'b0;
    items_sent    = 0;
    sb            = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    setting = '{primary_block: 4'h4, secondary_block: 4'hA, page_language: 3'd5,
                page_flags: 8'h10};
    program_regs(setting);

    // header row: loads not noted, header columns silent, row 0 boxed
    load_byte(0, 0, CODE_DBL_SIZE);
    load_byte(0, 3, 8'h8D);
    load_byte(0, 8, 8'h01);
    load_byte(0, 9, 8'h41);
    render_at(0, 0);
    render_at(0, 3);
    render_at(0, 8);
    render_at(0, 9);

    // size changes, skipped column, right edge fallback and blanking below
    load_byte(5, 0, CODE_DBL_HEIGHT);
    load_byte(5, 1, 8'h41);
    load_byte(5, 2, CODE_DBL_WIDTH);
    load_byte(5, 3, 8'h7F);
    load_byte(5, 4, CODE_DBL_SIZE);
    load_byte(5, 5, 8'h80);
    load_byte(5, 37, CODE_DBL_SIZE);
    load_byte(5, 38, 8'hFF);
    load_byte(5, 39, GLYPH_SPACE);
    load_byte(5, 63, CODE_DBL_HEIGHT);
    for (int c = 0; c < 6; c++) render_at(5, c);
    render_at(5, 37);
    render_at(5, 38);
    render_at(5, 39);
    render_at(9, 62);
    // bottom row: double height falls back
    render_at(TEXT_ROWS - 1, 0);
    render_at(TEXT_ROWS - 1, 1);
    settle();

    // random rows: load a prefix of the row, then render from column 0
    base = items_sent;
    seq  = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (seq > 0 && seq % 3 == 0) begin
        settle();
        case ((seq / 3) % 4)
          0: setting = '{primary_block: 4'hF, secondary_block: 4'hF, page_language: 3'd7,
                         page_flags: 8'hFF};
          1: setting = '0;
          default: begin
            setting.primary_block   = 4'($urandom);
            setting.secondary_block = 4'($urandom);
            setting.page_language   = 3'($urandom);
            setting.page_flags      = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
          end
        endcase
        program_regs(setting);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      r       = pick_row();
      loads   = (seq == 0 || $urandom_range(0, 3) == 0) ? ROW_COLUMNS
                                                          : $urandom_range(1, ROW_COLUMNS);
      renders = ($urandom_range(0, 3) == 0) ? ROW_COLUMNS : $urandom_range(1, ROW_COLUMNS);
      for (int c = 0; c < loads; c++) begin
        maybe_noise();
        load_byte(r, c, pick_code());
      end
      // one render burst runs against a long receiver hold-off
      if (seq == 4) begin
        tx_calm       = 1'b1;
        long_hold_req = 1'b1;
      end
      for (int c = 0; c < renders; c++) begin
        maybe_noise();
        if (col_loaded[c]) render_at(r, c);
      end
      seq++;
    end

    settle();
    if (sb.mismatches == 0 && sb.expected_cells.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
